>>> rtl/reader_progress_rank_defines.svh
// Assertion macros shared by the RTL. Each expects clk and arst_n in scope.
`ifndef READER_PROGRESS_RANK_DEFINES_SVH
`define READER_PROGRESS_RANK_DEFINES_SVH
`ifndef SYNTH
`define RPR_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define RPR_ASSERT_NEVER(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(prop)) else $error(msg);
`else
`define RPR_ASSERT(label, prop, msg)
`define RPR_ASSERT_NEVER(label, prop, msg)
`endif
`endif

>>> rtl/rpr_pkg.sv
package rpr_pkg;

	localparam int PAGE_W = 10;
	localparam int UID_W = 12;
	localparam int CNT_OUT_W = 12;
	localparam int FRAC_W = 16;
	localparam int RATIO_W = 17;
	localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

	// One classified request as it waits between the front and the back.
	typedef struct packed {
		logic              is_query;
		logic              uid_ok;
		logic [UID_W-1:0]  uid;
		logic [PAGE_W-1:0] page;
	} req_t;

endpackage

>>> rtl/reader_progress_rank.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | req_type, user_id, page_num
// out     | output    | out_valid/out_ready | ratio, behind_count, other_users, user_known
//
// A record request passes the back end through ST_URD and ST_HINC, and also ST_HDEC
// and ST_HRD when the user already had a page; it gives no result.
// A rank query reads the user table, then makes one histogram read per cycle over
// pages from 1 up to just below the user's page, then one quotient bit per cycle,
// before it raises out_valid; an unknown or sole user skips the sum and division.
// After reset a clearing pass over max(MAX_USERS, PAGE_SLOTS) addresses zeroes the
// user table and histogram; in_ready stays low until it ends.
// A two-entry queue accepts requests until full while the back end or out stalls.
module reader_progress_rank #(
	parameter int MAX_USERS = 4096,
	parameter int PAGE_SLOTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [rpr_pkg::UID_W-1:0]     user_id,
	input  logic [rpr_pkg::PAGE_W-1:0]    page_num,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rpr_pkg::RATIO_W-1:0]   ratio,
	output logic [rpr_pkg::CNT_OUT_W-1:0] behind_count,
	output logic [rpr_pkg::CNT_OUT_W-1:0] other_users,
	output logic                          user_known
);

	logic          accept_en;
	logic          q_valid;
	logic          q_pop;
	rpr_pkg::req_t q_head;

	rpr_front #(
		.MAX_USERS(MAX_USERS),
		.PAGE_SLOTS(PAGE_SLOTS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept_en(accept_en),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.user_id(user_id),
		.page_num(page_num),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop)
	);

	rpr_back #(
		.MAX_USERS(MAX_USERS),
		.PAGE_SLOTS(PAGE_SLOTS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.ready_for_req(accept_en),
		.q_valid(q_valid),
		.q_head(q_head),
		.q_pop(q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.ratio(ratio),
		.behind_count(behind_count),
		.other_users(other_users),
		.user_known(user_known)
	);

endmodule

>>> rtl/rpr_front.sv
module rpr_front #(
	parameter int MAX_USERS = 4096,
	parameter int PAGE_SLOTS = 1024
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept_en,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       req_type,
	input  logic [rpr_pkg::UID_W-1:0]  user_id,
	input  logic [rpr_pkg::PAGE_W-1:0] page_num,
	output logic                       q_valid,
	output rpr_pkg::req_t              q_head,
	input  logic                       q_pop
);

	rpr_pkg::req_t ent_q [2];
	rpr_pkg::req_t cls;
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          push;

	always_comb begin
		cls.is_query = req_type;
		cls.uid_ok = (32'(user_id) < MAX_USERS);
		cls.uid = user_id;
		if (32'(page_num) >= PAGE_SLOTS) begin
			cls.page = rpr_pkg::PAGE_W'(PAGE_SLOTS - 1);
		end else begin
			cls.page = page_num;
		end
	end

	assign in_ready = (cnt_q != 2'd2) && accept_en;
	assign push = in_valid && in_ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_head = ent_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (q_pop) begin
				rp_q <= ~rp_q;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (q_pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

>>> rtl/rpr_back.sv
`include "reader_progress_rank_defines.svh"
module rpr_back #(
	parameter int MAX_USERS = 4096,
	parameter int PAGE_SLOTS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	output logic                          ready_for_req,
	input  logic                          q_valid,
	input  rpr_pkg::req_t                 q_head,
	output logic                          q_pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [rpr_pkg::RATIO_W-1:0]   ratio,
	output logic [rpr_pkg::CNT_OUT_W-1:0] behind_count,
	output logic [rpr_pkg::CNT_OUT_W-1:0] other_users,
	output logic                          user_known
);

	localparam int UW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
	localparam int PW = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
	localparam int CW = $clog2(MAX_USERS + 1);
	localparam int NW = CW + rpr_pkg::FRAC_W;
	localparam int DCW = $clog2(NW + 1);
	localparam int CLR_N = (MAX_USERS > PAGE_SLOTS) ? MAX_USERS : PAGE_SLOTS;
	localparam int CLR_W = $clog2(CLR_N);
	localparam int UDW = rpr_pkg::PAGE_W + 1;

	typedef enum logic [8:0] {
		ST_CLEAR = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_URD   = 9'b000000100,
		ST_HDEC  = 9'b000001000,
		ST_HRD   = 9'b000010000,
		ST_HINC  = 9'b000100000,
		ST_SUM   = 9'b001000000,
		ST_DIV   = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	logic [UDW-1:0] umem [MAX_USERS];
	logic [CW-1:0]  hmem [PAGE_SLOTS];

	state_t                      state_q;
	logic [CLR_W-1:0]            clr_q;
	rpr_pkg::req_t               cur_q;
	logic [UDW-1:0]              u_rd_q;
	logic [CW-1:0]               h_rd_q;
	logic [PW-1:0]               old_q;
	logic [CW-1:0]               known_q;
	logic [PW-1:0]               idx_q;
	logic [PW-1:0]               own_q;
	logic                        pend_q;
	logic [CW-1:0]               behind_q;
	logic [CW-1:0]               others_q;
	logic [NW-1:0]               num_q;
	logic [CW-1:0]               rem_q;
	logic [NW-1:0]               quo_q;
	logic [DCW-1:0]              dcnt_q;
	logic [rpr_pkg::RATIO_W-1:0] res_ratio_q;
	logic                        res_known_q;
	logic                        out_valid_q;
	logic [rpr_pkg::RATIO_W-1:0] out_ratio_q;
	logic [CW-1:0]               out_behind_q;
	logic [CW-1:0]               out_others_q;
	logic                        out_known_q;

	logic                 u_we;
	logic [UW-1:0]        u_waddr;
	logic [UDW-1:0]       u_wdata;
	logic                 h_we;
	logic [PW-1:0]        h_waddr;
	logic [CW-1:0]        h_wdata;
	logic [PW-1:0]        h_raddr;
	logic [PW-1:0]        cur_page;
	logic [PW-1:0]        mem_page;
	logic                 mem_valid;
	logic [CW:0]          trial;
	logic                 out_free;
	logic                 out_zero;

	assign cur_page = PW'(cur_q.page);
	assign mem_page = PW'(u_rd_q[rpr_pkg::PAGE_W-1:0]);
	assign mem_valid = u_rd_q[UDW-1];
	assign trial = {rem_q, num_q[NW-1]};
	assign out_free = !out_valid_q || out_ready;
	assign q_pop = (state_q == ST_IDLE) && q_valid;
	assign ready_for_req = (state_q != ST_CLEAR);

	always_comb begin
		u_we = 1'b0;
		u_waddr = UW'(cur_q.uid);
		u_wdata = {1'b1, cur_q.page};
		h_we = 1'b0;
		h_waddr = cur_page;
		h_wdata = h_rd_q + CW'(1);
		h_raddr = cur_page;
		case (state_q)
			ST_CLEAR: begin
				u_we = (32'(clr_q) < MAX_USERS);
				u_waddr = UW'(clr_q);
				u_wdata = '0;
				h_we = (32'(clr_q) < PAGE_SLOTS);
				h_waddr = PW'(clr_q);
				h_wdata = '0;
			end
			ST_URD: begin
				if (!cur_q.is_query) begin
					u_we = 1'b1;
					if (mem_valid) begin
						h_raddr = mem_page;
					end
				end
			end
			ST_HDEC: begin
				h_waddr = old_q;
				h_we = (h_rd_q != '0);
				h_wdata = h_rd_q - CW'(1);
			end
			ST_HINC: begin
				h_we = 1'b1;
			end
			ST_SUM: begin
				h_raddr = idx_q;
			end
			default: begin
			end
		endcase
	end

	// Both stores have one write and one registered read port.
	always_ff @(posedge clk) begin
		if (u_we) begin
			umem[u_waddr] <= u_wdata;
		end
		u_rd_q <= umem[UW'(q_head.uid)];
	end

	always_ff @(posedge clk) begin
		if (h_we) begin
			hmem[h_waddr] <= h_wdata;
		end
		h_rd_q <= hmem[h_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			known_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(CLR_N - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (q_valid) begin
						if (q_head.uid_ok) begin
							state_q <= ST_URD;
						end else if (q_head.is_query) begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_URD: begin
					if (!cur_q.is_query) begin
						if (mem_valid) begin
							state_q <= ST_HDEC;
						end else begin
							known_q <= known_q + CW'(1);
							state_q <= ST_HINC;
						end
					end else if (!mem_valid || known_q <= CW'(1)) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_SUM;
					end
				end
				ST_HDEC: begin
					state_q <= ST_HRD;
				end
				ST_HRD: begin
					state_q <= ST_HINC;
				end
				ST_HINC: begin
					state_q <= ST_IDLE;
				end
				ST_SUM: begin
					if (!(idx_q < own_q) && !pend_q) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (dcnt_q == DCW'(NW)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cur_q <= q_head;
				res_ratio_q <= '0;
				res_known_q <= 1'b0;
				behind_q <= '0;
				others_q <= '0;
			end
			ST_URD: begin
				old_q <= mem_page;
				own_q <= mem_page;
				idx_q <= PW'(1);
				pend_q <= 1'b0;
				if (cur_q.is_query && mem_valid) begin
					res_known_q <= 1'b1;
					if (known_q <= CW'(1)) begin
						res_ratio_q <= rpr_pkg::RATIO_ONE;
					end else begin
						others_q <= known_q - CW'(1);
					end
				end
			end
			ST_SUM: begin
				// Reads are issued one slot ahead of the accumulation.
				if (pend_q) begin
					behind_q <= behind_q + h_rd_q;
				end
				if (idx_q < own_q) begin
					idx_q <= idx_q + PW'(1);
					pend_q <= 1'b1;
				end else begin
					pend_q <= 1'b0;
				end
				num_q <= {behind_q + (pend_q ? h_rd_q : '0), rpr_pkg::FRAC_W'(0)};
				rem_q <= '0;
				quo_q <= '0;
				dcnt_q <= '0;
			end
			ST_DIV: begin
				// Restoring division, one quotient bit per cycle.
				if (dcnt_q != DCW'(NW)) begin
					num_q <= {num_q[NW-2:0], 1'b0};
					dcnt_q <= dcnt_q + DCW'(1);
					if (trial >= {1'b0, others_q}) begin
						rem_q <= CW'(trial - {1'b0, others_q});
						quo_q <= {quo_q[NW-2:0], 1'b1};
					end else begin
						rem_q <= CW'(trial);
						quo_q <= {quo_q[NW-2:0], 1'b0};
					end
				end else if (quo_q > NW'(rpr_pkg::RATIO_ONE)) begin
					res_ratio_q <= rpr_pkg::RATIO_ONE;
				end else begin
					res_ratio_q <= rpr_pkg::RATIO_W'(quo_q);
				end
			end
			ST_OUT: begin
				if (out_free) begin
					out_ratio_q <= res_ratio_q;
					out_behind_q <= behind_q;
					out_others_q <= others_q;
					out_known_q <= res_known_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign ratio = out_ratio_q;
	assign behind_count = rpr_pkg::CNT_OUT_W'(out_behind_q);
	assign other_users = rpr_pkg::CNT_OUT_W'(out_others_q);
	assign user_known = out_known_q;
	assign out_zero = (out_ratio_q == '0) && (out_behind_q == '0) && (out_others_q == '0);

	`RPR_ASSERT(a_ratio_range, out_valid_q |-> out_ratio_q <= rpr_pkg::RATIO_ONE, "ratio above one")
	`RPR_ASSERT(a_unknown_zero, (out_valid_q && !out_known_q) |-> out_zero, "unknown user nonzero")
	`RPR_ASSERT(a_known_bound, 32'(known_q) <= MAX_USERS, "user total exceeds capacity")
	`RPR_ASSERT(a_behind_bound, (state_q == ST_DIV) |-> behind_q <= others_q, "behind too large")
	`RPR_ASSERT_NEVER(a_no_pop_in_clear, (state_q == ST_CLEAR) && q_pop, "pop during clear")

endmodule
